/* hw/rtl/rufd_pkg.sv */
package rufd_pkg;

    localparam int unsigned RECORD_BYTES_DEF = 46;

    localparam int unsigned CNT_W  = 17;
    localparam int unsigned SPAN_W = 16;
    localparam int unsigned OFF_W  = 16;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HEAD = 2'd1,
        PH_DATA = 2'd2,
        PH_TAIL = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ROLE_HEADER  = 2'd0,
        ROLE_PAYLOAD = 2'd1,
        ROLE_CHECK   = 2'd2,
        ROLE_TAIL    = 2'd3
    } role_t;

    localparam logic FMT_SHORT = 1'b0;
    localparam logic FMT_SYTC  = 1'b1;

    localparam logic [7:0] SYNC_S   = 8'h53;
    localparam logic [7:0] SYNC_Y   = 8'h59;
    localparam logic [7:0] SYNC_T   = 8'h54;
    localparam logic [7:0] SYNC_C   = 8'h43;
    localparam logic [7:0] TAIL0_F0 = 8'h54;
    localparam logic [7:0] TAIL1_F0 = 8'h43;
    localparam logic [7:0] TAIL_F1  = 8'hEE;

    // Header byte offsets: last header byte and the byte holding length high / record count
    localparam logic [CNT_W-1:0] HEAD_LAST_F0 = CNT_W'(3);
    localparam logic [CNT_W-1:0] HEAD_LAST_F1 = CNT_W'(10);
    localparam logic [CNT_W-1:0] HEAD_KEEP_F0 = CNT_W'(2);
    localparam logic [CNT_W-1:0] HEAD_KEEP_F1 = CNT_W'(5);

endpackage

/* hw/rtl/rufd_rx_if.sv */
interface rufd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       resync;

    modport source (output valid, output rx_byte, output resync, input ready);
    modport sink   (input valid, input rx_byte, input resync, output ready);
endinterface

/* hw/rtl/rufd_tx_if.sv */
interface rufd_tx_if;
    logic                      valid;
    logic                      ready;
    logic [7:0]                out_byte;
    logic [1:0]                byte_role;
    logic [rufd_pkg::OFF_W-1:0] section_offset;
    logic                      frame_end;
    logic                      frame_good;

    modport source (output valid, output out_byte, output byte_role, output section_offset,
                    output frame_end, output frame_good, input ready);
    modport sink   (input valid, input out_byte, input byte_role, input section_offset,
                    input frame_end, input frame_good, output ready);
endinterface

/* hw/rtl/rufd_cfg_if.sv */
interface rufd_cfg_if;
    logic valid;
    logic ready;
    logic frame_format;

    modport source (output valid, output frame_format, input ready);
    modport sink   (input valid, input frame_format, output ready);
endinterface

/* hw/rtl/radar_uart_frame_deframer.sv */
// Byte deframer for two serial radar frame formats, chosen by frame_format
// (0: 0x53 0x59 sync, 4 header bytes with a 16-bit length, payload, 1 check byte,
// tail 0x54 0x43; 1: "SYTC" sync, 11 header bytes with a record count at header
// byte 5, RECORD_BYTES per record, 2 CRC bytes, tail 0xEE 0xEE). Every header,
// payload, check and tail byte comes out tagged with its role and its offset in
// its section; sync bytes and resync words give no output. frame_end marks the
// last tail byte and frame_good says whether both tail bytes matched. The block
// takes one byte per cycle while rx.ready is high: each word is decoded
// combinationally against the phase and count registers and lands in one
// output register, and the input stays ready while that register is empty or
// being drained and no format write is offered. A taken byte shows the next cycle.
// A write to frame_format drops any frame in progress and resumes hunting.
module radar_uart_frame_deframer #(
    parameter int unsigned RECORD_BYTES = rufd_pkg::RECORD_BYTES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    rufd_cfg_if.sink      cfg,
    rufd_rx_if.sink       rx,
    rufd_tx_if.source     tx
);

    localparam logic [7:0] REC_BYTES = 8'(RECORD_BYTES);

    rufd_pkg::phase_t                 phase_reg, phase_next;
    logic [rufd_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [rufd_pkg::SPAN_W-1:0]      span_reg, span_next;
    logic                             mism_reg, mism_next;
    logic                             tail_ok_reg, tail_ok_next;
    logic [7:0]                       save_reg, save_next;
    logic                             fmt_reg;

    logic                             out_valid_reg;
    logic [7:0]                       out_byte_reg;
    rufd_pkg::role_t                  out_role_reg;
    logic [rufd_pkg::OFF_W-1:0]       out_off_reg;
    logic                             out_end_reg;
    logic                             out_good_reg;

    logic                             out_free;
    logic                             rx_take;
    logic                             res_valid;
    rufd_pkg::role_t                  res_role;
    logic [rufd_pkg::CNT_W-1:0]       res_off;
    logic                             res_end;
    logic                             res_good;

    logic [7:0]                       b;
    logic [7:0]                       want;
    logic                             mism_acc;
    logic [rufd_pkg::CNT_W-1:0]       head_last;
    logic [rufd_pkg::CNT_W-1:0]       head_keep;
    logic [rufd_pkg::CNT_W-1:0]       span_ext;
    logic [rufd_pkg::CNT_W-1:0]       check_off;
    logic [15:0]                      rec_span;
    logic [7:0]                       tail0;
    logic [7:0]                       tail1;

    assign cfg.ready = 1'b1;
    assign out_free  = !out_valid_reg || tx.ready;
    // hold the input while a format write is offered
    assign rx.ready  = out_free && !cfg.valid;
    assign rx_take   = rx.valid && rx.ready;
    assign b         = rx.rx_byte;

    assign head_last = (fmt_reg == rufd_pkg::FMT_SYTC) ? rufd_pkg::HEAD_LAST_F1
                                                       : rufd_pkg::HEAD_LAST_F0;
    assign head_keep = (fmt_reg == rufd_pkg::FMT_SYTC) ? rufd_pkg::HEAD_KEEP_F1
                                                       : rufd_pkg::HEAD_KEEP_F0;
    assign span_ext  = {1'b0, span_reg};
    assign check_off = cnt_reg - span_ext;
    assign rec_span  = {8'd0, REC_BYTES} * {8'd0, save_reg};
    assign tail0     = (fmt_reg == rufd_pkg::FMT_SYTC) ? rufd_pkg::TAIL_F1
                                                       : rufd_pkg::TAIL0_F0;
    assign tail1     = (fmt_reg == rufd_pkg::FMT_SYTC) ? rufd_pkg::TAIL_F1
                                                       : rufd_pkg::TAIL1_F0;

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd1:    want = rufd_pkg::SYNC_Y;
            2'd2:    want = rufd_pkg::SYNC_T;
            default: want = rufd_pkg::SYNC_C;
        endcase
        mism_acc = mism_reg || (b != want);
    end

    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        span_next    = span_reg;
        mism_next    = mism_reg;
        tail_ok_next = tail_ok_reg;
        save_next    = save_reg;
        res_valid    = 1'b0;
        res_role     = rufd_pkg::ROLE_HEADER;
        res_off      = cnt_reg;
        res_end      = 1'b0;
        res_good     = 1'b0;

        if (rx.resync)
        begin
            phase_next   = rufd_pkg::PH_HUNT;
            cnt_next     = '0;
            span_next    = '0;
            mism_next    = 1'b0;
            tail_ok_next = 1'b0;
            save_next    = '0;
        end
        else
        begin
            case (phase_reg)
                rufd_pkg::PH_HUNT:
                begin
                    if (fmt_reg == rufd_pkg::FMT_SHORT)
                    begin
                        if (cnt_reg == '0 && b == rufd_pkg::SYNC_S)
                        begin
                            cnt_next = rufd_pkg::CNT_W'(1);
                        end
                        else if (cnt_reg == rufd_pkg::CNT_W'(1) && b == rufd_pkg::SYNC_Y)
                        begin
                            phase_next = rufd_pkg::PH_HEAD;
                            cnt_next   = '0;
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        if (b == rufd_pkg::SYNC_S)
                        begin
                            cnt_next  = rufd_pkg::CNT_W'(1);
                            mism_next = 1'b0;
                        end
                    end
                    else
                    begin
                        // take all three remaining sync words, judge after the last
                        mism_next = mism_acc;
                        if (cnt_reg == rufd_pkg::CNT_W'(3))
                        begin
                            cnt_next = '0;
                            if (!mism_acc)
                            begin
                                phase_next = rufd_pkg::PH_HEAD;
                            end
                        end
                        else
                        begin
                            cnt_next = cnt_reg + rufd_pkg::CNT_W'(1);
                        end
                    end
                end

                rufd_pkg::PH_HEAD:
                begin
                    res_valid = 1'b1;
                    res_role  = rufd_pkg::ROLE_HEADER;
                    if (cnt_reg == head_keep)
                    begin
                        save_next = b;
                    end
                    if (cnt_reg == head_last)
                    begin
                        span_next  = (fmt_reg == rufd_pkg::FMT_SYTC) ? rec_span : {save_reg, b};
                        phase_next = rufd_pkg::PH_DATA;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + rufd_pkg::CNT_W'(1);
                    end
                end

                rufd_pkg::PH_DATA:
                begin
                    res_valid = 1'b1;
                    if (cnt_reg < span_ext)
                    begin
                        res_role = rufd_pkg::ROLE_PAYLOAD;
                        cnt_next = cnt_reg + rufd_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        res_role = rufd_pkg::ROLE_CHECK;
                        res_off  = check_off;
                        // format 0 has one check byte, format 1 two CRC bytes
                        if (fmt_reg == rufd_pkg::FMT_SHORT || check_off != '0)
                        begin
                            phase_next = rufd_pkg::PH_TAIL;
                            cnt_next   = '0;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + rufd_pkg::CNT_W'(1);
                        end
                    end
                end

                rufd_pkg::PH_TAIL:
                begin
                    res_valid = 1'b1;
                    res_role  = rufd_pkg::ROLE_TAIL;
                    if (cnt_reg == '0)
                    begin
                        tail_ok_next = (b == tail0);
                        cnt_next     = rufd_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        res_off      = rufd_pkg::CNT_W'(1);
                        res_end      = 1'b1;
                        res_good     = tail_ok_reg && (b == tail1);
                        phase_next   = rufd_pkg::PH_HUNT;
                        cnt_next     = '0;
                        span_next    = '0;
                        mism_next    = 1'b0;
                        tail_ok_next = 1'b0;
                        save_next    = '0;
                    end
                end

                default:
                begin
                    phase_next = rufd_pkg::PH_HUNT;
                    cnt_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg     <= rufd_pkg::FMT_SHORT;
            phase_reg   <= rufd_pkg::PH_HUNT;
            cnt_reg     <= '0;
            span_reg    <= '0;
            mism_reg    <= 1'b0;
            tail_ok_reg <= 1'b0;
            save_reg    <= '0;
        end
        else if (cfg.valid)
        begin
            // new format: drop the frame in progress
            fmt_reg     <= cfg.frame_format;
            phase_reg   <= rufd_pkg::PH_HUNT;
            cnt_reg     <= '0;
            span_reg    <= '0;
            mism_reg    <= 1'b0;
            tail_ok_reg <= 1'b0;
            save_reg    <= '0;
        end
        else if (rx_take)
        begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            span_reg    <= span_next;
            mism_reg    <= mism_next;
            tail_ok_reg <= tail_ok_next;
            save_reg    <= save_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= rx_take && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take && res_valid)
        begin
            out_byte_reg <= b;
            out_role_reg <= res_role;
            out_off_reg  <= res_off[rufd_pkg::OFF_W-1:0];
            out_end_reg  <= res_end;
            out_good_reg <= res_good;
        end
    end

    assign tx.valid          = out_valid_reg;
    assign tx.out_byte       = out_byte_reg;
    assign tx.byte_role      = out_role_reg;
    assign tx.section_offset = out_off_reg;
    assign tx.frame_end      = out_end_reg;
    assign tx.frame_good     = out_good_reg;

    a_hunt_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == rufd_pkg::PH_HUNT |-> cnt_reg < rufd_pkg::CNT_W'(4))
        else $error("hunt count out of range");

    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == rufd_pkg::PH_DATA |-> cnt_reg <= span_ext + rufd_pkg::CNT_W'(1))
        else $error("data count past check bytes");

    a_good_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_good_reg |-> out_end_reg)
        else $error("frame_good without frame_end");

    a_resync: assert property (@(posedge clk) disable iff (!rst_n)
        rx_take && rx.resync |=> phase_reg == rufd_pkg::PH_HUNT && cnt_reg == '0)
        else $error("resync did not return to hunting");

endmodule

/* verif/radar_uart_frame_deframer_checker.sv */
`timescale 1ns / 100ps
module radar_uart_frame_deframer_checker #(
    parameter int unsigned RECORD_BYTES = rufd_pkg::RECORD_BYTES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    rufd_cfg_if  cfg,
    rufd_rx_if   rx,
    rufd_tx_if   tx,
    output int   fail_count,
    output int   pending,
    output int   words_checked,
    output int   frames_good,
    output int   frames_bad
);

    localparam int MAX_REPORTS = 30;

    typedef struct packed {
        logic [7:0]                 data;
        rufd_pkg::role_t            role;
        logic [rufd_pkg::OFF_W-1:0] offset;
        logic                       last;
        logic                       good;
    } frame_word_t;

    // shadow copy of the deframer state
    logic                       fmt;
    rufd_pkg::phase_t           phase;
    logic [rufd_pkg::CNT_W-1:0] pos;
    logic [rufd_pkg::CNT_W-1:0] span;
    logic                       sync_bad;
    logic                       tail0_ok;
    logic [7:0]                 len_hi;

    frame_word_t expected_words[$];

    function automatic frame_word_t make_word(input logic [7:0] b, input rufd_pkg::role_t role,
                                              input logic [rufd_pkg::OFF_W-1:0] off,
                                              input logic last, input logic good);
        frame_word_t w;
        w.data   = b;
        w.role   = role;
        w.offset = off;
        w.last   = last;
        w.good   = good;
        return w;
    endfunction

    function automatic void clear_frame();
        phase    = rufd_pkg::PH_HUNT;
        pos      = '0;
        span     = '0;
        sync_bad = 1'b0;
        tail0_ok = 1'b0;
        len_hi   = '0;
    endfunction

    // Advance the shadow state by one received word; return 1 when it yields an output word.
    function automatic logic deframe_word(input logic [7:0] b, input logic rs,
                                          output frame_word_t w);
        logic                       hit;
        logic [7:0]                 want;
        logic [rufd_pkg::CNT_W-1:0] last_off;
        logic [rufd_pkg::CNT_W-1:0] keep_off;
        logic [rufd_pkg::CNT_W-1:0] coff;
        logic [7:0]                 t0;
        logic [7:0]                 t1;
        hit = 1'b0;
        w   = '0;
        if (rs) begin
            clear_frame();
        end
        else begin
            case (phase)
                rufd_pkg::PH_HUNT:
                begin
                    if (fmt == rufd_pkg::FMT_SHORT) begin
                        if (pos == 0 && b == rufd_pkg::SYNC_S)
                            pos = rufd_pkg::CNT_W'(1);
                        else if (pos == 1 && b == rufd_pkg::SYNC_Y) begin
                            phase = rufd_pkg::PH_HEAD;
                            pos   = '0;
                        end
                    end
                    else if (pos == 0) begin
                        if (b == rufd_pkg::SYNC_S) begin
                            pos      = rufd_pkg::CNT_W'(1);
                            sync_bad = 1'b0;
                        end
                    end
                    else begin
                        // the three letters after S are always taken, right or wrong
                        want = (pos == 1) ? rufd_pkg::SYNC_Y
                             : (pos == 2) ? rufd_pkg::SYNC_T : rufd_pkg::SYNC_C;
                        if (b != want)
                            sync_bad = 1'b1;
                        pos = pos + 1'b1;
                        if (pos >= 4) begin
                            pos = '0;
                            if (!sync_bad)
                                phase = rufd_pkg::PH_HEAD;
                        end
                    end
                end
                rufd_pkg::PH_HEAD:
                begin
                    last_off = (fmt == rufd_pkg::FMT_SYTC) ? rufd_pkg::HEAD_LAST_F1
                                                           : rufd_pkg::HEAD_LAST_F0;
                    keep_off = (fmt == rufd_pkg::FMT_SYTC) ? rufd_pkg::HEAD_KEEP_F1
                                                           : rufd_pkg::HEAD_KEEP_F0;
                    w   = make_word(b, rufd_pkg::ROLE_HEADER, pos[rufd_pkg::OFF_W-1:0],
                                    1'b0, 1'b0);
                    hit = 1'b1;
                    if (pos == keep_off)
                        len_hi = b;
                    if (pos >= last_off) begin
                        if (fmt == rufd_pkg::FMT_SYTC)
                            span = rufd_pkg::CNT_W'(RECORD_BYTES * len_hi);
                        else
                            span = {1'b0, len_hi, b};
                        phase = rufd_pkg::PH_DATA;
                        pos   = '0;
                    end
                    else
                        pos = pos + 1'b1;
                end
                rufd_pkg::PH_DATA:
                begin
                    hit = 1'b1;
                    if (pos < span) begin
                        w   = make_word(b, rufd_pkg::ROLE_PAYLOAD, pos[rufd_pkg::OFF_W-1:0],
                                        1'b0, 1'b0);
                        pos = pos + 1'b1;
                    end
                    else begin
                        coff = pos - span;
                        w    = make_word(b, rufd_pkg::ROLE_CHECK, coff[rufd_pkg::OFF_W-1:0],
                                         1'b0, 1'b0);
                        if (coff >= rufd_pkg::CNT_W'(fmt)) begin
                            phase = rufd_pkg::PH_TAIL;
                            pos   = '0;
                        end
                        else
                            pos = pos + 1'b1;
                    end
                end
                default:
                begin
                    t0  = (fmt == rufd_pkg::FMT_SYTC) ? rufd_pkg::TAIL_F1 : rufd_pkg::TAIL0_F0;
                    t1  = (fmt == rufd_pkg::FMT_SYTC) ? rufd_pkg::TAIL_F1 : rufd_pkg::TAIL1_F0;
                    hit = 1'b1;
                    if (pos == 0) begin
                        tail0_ok = (b == t0);
                        w        = make_word(b, rufd_pkg::ROLE_TAIL, rufd_pkg::OFF_W'(0),
                                             1'b0, 1'b0);
                        pos      = rufd_pkg::CNT_W'(1);
                    end
                    else begin
                        w = make_word(b, rufd_pkg::ROLE_TAIL, rufd_pkg::OFF_W'(1), 1'b1,
                                      tail0_ok && b == t1);
                        clear_frame();
                    end
                end
            endcase
        end
        return hit;
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin : monitor
        frame_word_t got;
        frame_word_t want;
        frame_word_t next_word;
        if (!rst_n) begin
            fmt = rufd_pkg::FMT_SHORT;
            clear_frame();
            expected_words.delete();
            fail_count    = 0;
            pending       = 0;
            words_checked = 0;
            frames_good   = 0;
            frames_bad    = 0;
        end
        else begin
            // the output word at this edge comes from a word taken at an earlier edge
            if (tx.valid && tx.ready) begin
                got = make_word(tx.out_byte, rufd_pkg::role_t'(tx.byte_role),
                                tx.section_offset, tx.frame_end, tx.frame_good);
                words_checked++;
                if (got.last) begin
                    if (got.good)
                        frames_good++;
                    else
                        frames_bad++;
                end
                if (expected_words.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected word, expected none, actual %0h", $time, got);
                end
                else begin
                    want = expected_words.pop_front();
                    compare_field("out_byte", want.data, got.data);
                    compare_field("byte_role", want.role, got.role);
                    compare_field("section_offset", want.offset, got.offset);
                    compare_field("frame_end", want.last, got.last);
                    compare_field("frame_good", want.good, got.good);
                end
            end
            if (cfg.valid && cfg.ready) begin
                fmt = cfg.frame_format;
                clear_frame();
            end
            if (rx.valid && rx.ready) begin
                if (deframe_word(rx.rx_byte, rx.resync, next_word))
                    expected_words.push_back(next_word);
            end
            pending = expected_words.size();
        end
    end

endmodule

/* verif/radar_uart_frame_deframer_tb.sv */
`timescale 1ns / 100ps
module radar_uart_frame_deframer_tb;

    localparam int IDLE_LIMIT    = 2000;
    localparam int PHASE_WORDS   = 250;
    localparam int RANDOM_PHASES = 6;

    logic clk;
    logic rst_n;
    logic calm;
    int   fail_count;
    int   pending;
    int   words_checked;
    int   frames_good;
    int   frames_bad;
    int   framed_total;

    // {resync, byte} words waiting to go out
    logic [8:0] line_words[$];

    rufd_cfg_if cfg();
    rufd_rx_if  rx();
    rufd_tx_if  tx();

    radar_uart_frame_deframer i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .rx    (rx),
        .tx    (tx)
    );

    radar_uart_frame_deframer_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .rx            (rx),
        .tx            (tx),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_checked (words_checked),
        .frames_good   (frames_good),
        .frames_bad    (frames_bad)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic queue_word(input logic [7:0] b, input logic rs);
        line_words.push_back({rs, b});
    endtask

    task automatic queue_short_frame(input logic [15:0] length);
        queue_word(rufd_pkg::SYNC_S, 1'b0);
        queue_word(rufd_pkg::SYNC_Y, 1'b0);
        queue_word(8'($urandom), 1'b0);
        queue_word(8'($urandom), 1'b0);
        queue_word(length[15:8], 1'b0);
        queue_word(length[7:0], 1'b0);
        repeat (length) queue_word(8'($urandom), 1'b0);
        queue_word(8'($urandom), 1'b0);
        queue_word(rufd_pkg::TAIL0_F0, 1'b0);
        queue_word(rufd_pkg::TAIL1_F0, 1'b0);
    endtask

    task automatic queue_sytc_frame(input logic [7:0] records);
        queue_word(rufd_pkg::SYNC_S, 1'b0);
        queue_word(rufd_pkg::SYNC_Y, 1'b0);
        queue_word(rufd_pkg::SYNC_T, 1'b0);
        queue_word(rufd_pkg::SYNC_C, 1'b0);
        for (int i = 0; i < 11; i++)
            queue_word((i == 5) ? records : 8'($urandom), 1'b0);
        repeat (rufd_pkg::RECORD_BYTES_DEF * records) queue_word(8'($urandom), 1'b0);
        queue_word(8'($urandom), 1'b0);
        queue_word(8'($urandom), 1'b0);
        queue_word(rufd_pkg::TAIL_F1, 1'b0);
        queue_word(rufd_pkg::TAIL_F1, 1'b0);
    endtask

    // Flip bits of the queued word at position idx.
    task automatic spoil_word(input int idx);
        line_words[idx][7:0] = line_words[idx][7:0] ^ 8'($urandom_range(1, 255));
    endtask

    task automatic send_line();
        logic [8:0] w;
        while (line_words.size() > 0) begin
            w = line_words.pop_front();
            if (!calm && $urandom_range(0, 7) == 0) begin
                rx.valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            rx.valid   <= 1'b1;
            rx.rx_byte <= w[7:0];
            rx.resync  <= w[8];
            @(posedge clk);
            while (!rx.ready) @(posedge clk);
            @(negedge clk);
        end
    endtask

    task automatic set_format(input logic value);
        rx.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        // a sync word may still be in flight with no output expected
        repeat (3) @(negedge clk);
        cfg.frame_format <= value;
        cfg.valid        <= 1'b1;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic queue_random_frame(input logic fmt, output int framed);
        int          kind;
        int          cut;
        logic [7:0]  junk;
        logic [15:0] length;
        kind   = $urandom_range(0, 15);
        framed = 0;
        if (kind == 0) begin
            // line noise, then close the link so the next frame starts clean
            repeat ($urandom_range(1, 6))
                queue_word(($urandom_range(0, 3) == 0) ? rufd_pkg::SYNC_S : 8'($urandom), 1'b0);
            queue_word(8'($urandom), 1'b1);
        end
        else if (fmt == rufd_pkg::FMT_SYTC && kind == 2) begin
            queue_word(rufd_pkg::SYNC_S, 1'b0);
            queue_word(rufd_pkg::SYNC_Y, 1'b0);
            queue_word(rufd_pkg::SYNC_T, 1'b0);
            queue_word(rufd_pkg::SYNC_C, 1'b0);
            spoil_word($urandom_range(1, 3));
            framed = line_words.size();
        end
        else begin
            if (fmt == rufd_pkg::FMT_SHORT) begin
                if ($urandom_range(0, 99) == 0)
                    length = 16'($urandom_range(256, 511));
                else if ($urandom_range(0, 19) == 0)
                    length = 16'($urandom_range(13, 255));
                else
                    length = 16'($urandom_range(0, 12));
                queue_short_frame(length);
                if (kind == 2) begin
                    // stray words between the two sync words are skipped
                    repeat ($urandom_range(1, 3)) begin
                        junk = 8'($urandom);
                        if (junk == rufd_pkg::SYNC_Y)
                            junk = 8'h00;
                        line_words.insert(1, {1'b0, junk});
                    end
                end
            end
            else
                queue_sytc_frame(($urandom_range(0, 19) == 0) ? 8'd3 : 8'($urandom_range(0, 2)));
            if (kind == 3 || kind == 4)
                spoil_word(line_words.size() - $urandom_range(1, 2));
            if (kind == 1) begin
                cut = $urandom_range(1, line_words.size() - 2);
                while (line_words.size() > cut) void'(line_words.pop_back());
                queue_word(8'($urandom), 1'b1);
            end
            framed = line_words.size();
        end
    endtask

    // output side: ready in random stretches, broken by random stalls unless calm
    initial
    begin
        tx.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            tx.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge clk);
            if (!calm && $urandom_range(0, 1) == 0) begin
                tx.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (rx.valid && rx.ready) || (tx.valid && tx.ready) ||
                (cfg.valid && cfg.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: timeout, no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int framed;
        rst_n            = 1'b0;
        calm             = 1'b0;
        framed_total     = 0;
        rx.valid         = 1'b0;
        rx.rx_byte       = '0;
        rx.resync        = 1'b0;
        cfg.valid        = 1'b0;
        cfg.frame_format = rufd_pkg::FMT_SHORT;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // short format: junk before sync, ignored word between S and Y,
        // one-word payload, empty payload with a bad second tail word, resync in header
        set_format(rufd_pkg::FMT_SHORT);
        queue_word(8'hFF, 1'b0);
        queue_word(rufd_pkg::SYNC_S, 1'b0);
        queue_word(8'h00, 1'b0);
        queue_short_frame(16'd1);
        queue_short_frame(16'd0);
        spoil_word(line_words.size() - 1);
        queue_word(rufd_pkg::SYNC_S, 1'b0);
        queue_word(rufd_pkg::SYNC_Y, 1'b0);
        queue_word(8'h12, 1'b0);
        queue_word(8'hFF, 1'b1);
        queue_word(rufd_pkg::SYNC_S, 1'b0);
        queue_word(rufd_pkg::SYNC_Y, 1'b0);
        queue_word(8'h34, 1'b0);
        send_line();

        // format write in the middle of a header drops that frame
        set_format(rufd_pkg::FMT_SYTC);
        // SYTC: bad third letter, empty record list with a bad first tail word, one record
        queue_word(rufd_pkg::SYNC_S, 1'b0);
        queue_word(rufd_pkg::SYNC_Y, 1'b0);
        queue_word(8'h58, 1'b0);
        queue_word(rufd_pkg::SYNC_C, 1'b0);
        queue_sytc_frame(8'd0);
        spoil_word(line_words.size() - 2);
        queue_sytc_frame(8'd1);
        send_line();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_format((p % 2 == 0) ? rufd_pkg::FMT_SYTC : rufd_pkg::FMT_SHORT);
            if (p == RANDOM_PHASES - 1)
                calm = 1'b1;
            framed = 0;
            for (int n = 0; n < PHASE_WORDS; n += framed) begin
                queue_random_frame((p % 2 == 0) ? rufd_pkg::FMT_SYTC : rufd_pkg::FMT_SHORT,
                                   framed);
                send_line();
                framed_total += framed;
            end
        end

        rx.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        $display("Sent %0d framed input words in both formats with resyncs and format changes;",
                 framed_total);
        $display("checked %0d output words, %0d frames ended good and %0d bad.",
                 words_checked, frames_good, frames_bad);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
